/* src/hbe_pkg.sv */
// Shared types, codes and constants of the hover-ball environment step unit.
// Holds the exponent table generator functions used at elaboration.
// No dependencies.
package hbe_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRAVITY      = 3'd0,
    CFG_TIME_STEP    = 3'd1,
    CFG_TARGET       = 3'd2,
    CFG_HEIGHT_LIMIT = 3'd3,
    CFG_STEP_LIMIT   = 3'd4,
    CFG_THRUST       = 3'd5,
    CFG_SPEED_LIMIT  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [23:0] gravity_accel;
    logic [15:0]        time_step;
    logic [22:0]        target_height;
    logic [22:0]        height_limit;
    logic [15:0]        step_limit;
    logic [22:0]        thrust_accel;
    logic [22:0]        speed_limit;
  } cfg_t;

  localparam logic signed [23:0] GravityRst     = -24'sd642253;
  localparam logic [15:0]        TimeStepRst    = 16'd655;
  localparam logic [22:0]        TargetRst      = 23'd655360;
  localparam logic [22:0]        HeightLimitRst = 23'd1310720;
  localparam logic [15:0]        StepLimitRst   = 16'd500;
  localparam logic [22:0]        ThrustRst      = 23'd983040;
  localparam logic [22:0]        SpeedLimitRst  = 23'd655360;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_RESET = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DV,
    ST_VEL,
    ST_MUL_DH,
    ST_HGT,
    ST_MUL_P,
    ST_ROM,
    ST_MUL_I,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic mul_dv;
    logic vel;
    logic mul_dh;
    logic hgt;
    logic mul_p;
    logic rom;
    logic mul_i;
    logic commit;
  } cmd_t;

  localparam logic signed [24:0] RewardCrash = -25'sd131072;
  localparam logic signed [24:0] RewardBias  = 25'sd3277;
  localparam logic [23:0]        Div10Mult   = 24'd13421773;
  localparam int unsigned        Div10Shift  = 27;

  // exp(-16/N) in Q0.30 from an alternating series, d = 2^34/N
  function automatic logic [63:0] exp_ratio_q30(input logic [63:0] d);
    logic [63:0] term;
    longint      sum;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int k = 1; k <= 20; k++) begin
      term = ((term * d) >> 30) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 64'(sum);
  endfunction

  // entry i of the table in Q1.16: ratio^i in Q0.30, rounded at each step
  function automatic logic [16:0] exp_entry(input logic [63:0] e, input int unsigned i);
    logic [63:0] cur;
    logic [63:0] rnd;
    cur = 64'd1 << 30;
    for (int unsigned j = 0; j < i; j++) begin
      cur = (cur * e + (64'd1 << 29)) >> 30;
    end
    rnd = (cur + (64'd1 << 13)) >> 14;
    return rnd[16:0];
  endfunction

endpackage

/* src/hbe_cfg_regs.sv */
// Configuration register bank of the hover-ball environment step unit.
// Depends on hbe_pkg.
module hbe_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hbe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hbe_pkg::CfgDataW-1:0]  cfg_data_i,
  output hbe_pkg::cfg_t                 cfg_o
);
  import hbe_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRAVITY:      cfg_d.gravity_accel = $signed(cfg_data_i);
        CFG_TIME_STEP:    cfg_d.time_step     = cfg_data_i[15:0];
        CFG_TARGET:       cfg_d.target_height = cfg_data_i[22:0];
        CFG_HEIGHT_LIMIT: cfg_d.height_limit  = cfg_data_i[22:0];
        CFG_STEP_LIMIT:   cfg_d.step_limit    = cfg_data_i[15:0];
        CFG_THRUST:       cfg_d.thrust_accel  = cfg_data_i[22:0];
        CFG_SPEED_LIMIT:  cfg_d.speed_limit   = cfg_data_i[22:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_accel <= GravityRst;
      cfg_q.time_step     <= TimeStepRst;
      cfg_q.target_height <= TargetRst;
      cfg_q.height_limit  <= HeightLimitRst;
      cfg_q.step_limit    <= StepLimitRst;
      cfg_q.thrust_accel  <= ThrustRst;
      cfg_q.speed_limit   <= SpeedLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/hbe_ctrl.sv */
// Sequencer of the hover-ball environment step unit: input handshake,
// datapath commands and the output valid flag. Depends on hbe_pkg.
module hbe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          operation_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hbe_pkg::cmd_t cmd_o
);
  import hbe_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_e'(operation_i) == OP_RESET) ? ST_COMMIT : ST_MUL_DV;
        end
      end
      ST_MUL_DV: state_d = ST_VEL;
      ST_VEL:    state_d = ST_MUL_DH;
      ST_MUL_DH: state_d = ST_HGT;
      ST_HGT:    state_d = ST_MUL_P;
      ST_MUL_P:  state_d = ST_ROM;
      ST_ROM:    state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:   cmd_o.capture = in_valid_i;
      ST_MUL_DV: cmd_o.mul_dv  = 1'b1;
      ST_VEL:    cmd_o.vel     = 1'b1;
      ST_MUL_DH: cmd_o.mul_dh  = 1'b1;
      ST_HGT:    cmd_o.hgt     = 1'b1;
      ST_MUL_P:  cmd_o.mul_p   = 1'b1;
      ST_ROM:    cmd_o.rom     = 1'b1;
      ST_MUL_I:  cmd_o.mul_i   = 1'b1;
      ST_COMMIT: cmd_o.commit  = out_free;
      default:   cmd_o         = '0;
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/hbe_datapath.sv */
// Datapath of the hover-ball environment step unit: ball state, shared
// product register, exponent table and reward. Depends on hbe_pkg.
module hbe_datapath #(
  parameter int unsigned EXP_TABLE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hbe_pkg::cfg_t      cfg_i,
  input  hbe_pkg::cmd_t      cmd_i,
  input  logic               operation_i,
  input  logic [1:0]         action_i,
  input  logic [22:0]        start_height_i,
  output logic signed [23:0] height_o,
  output logic signed [23:0] velocity_o,
  output logic signed [23:0] reward_o,
  output logic               episode_done_o,
  output logic               crash_terminal_o
);
  import hbe_pkg::*;

  localparam int unsigned IdxW     = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int unsigned PW       = 20 + IdxW;
  localparam logic [63:0] ExpD     = (64'd16 << 30) / 64'(EXP_TABLE_ENTRIES);
  localparam logic [63:0] ExpRatio = exp_ratio_q30(ExpD);
  localparam logic [1:0]  ActDown  = 2'd0;
  localparam logic [1:0]  ActUp    = 2'd2;

  logic [16:0] exp_rom [EXP_TABLE_ENTRIES + 1];

  for (genvar gi = 0; gi <= EXP_TABLE_ENTRIES; gi++) begin : g_rom
    assign exp_rom[gi] = exp_entry(ExpRatio, gi);
  end

  op_e                op_q;
  logic [22:0]        start_q;
  logic signed [24:0] accel_d, accel_q;
  logic signed [41:0] mul_q, mul_rnd;
  logic signed [23:0] vnew_q, hnew_q;
  logic [47:0]        div_q;
  logic               far_q, crash_q;
  logic [PW-1:0]      p_q;
  logic [16:0]        a_q, b_q;
  logic [15:0]        f_q;
  logic signed [34:0] ip_q, ip_rnd;
  logic signed [23:0] height_q, vel_q, reward_q;
  logic [15:0]        cnt_q;
  logic               done_q, term_q;

  logic signed [24:0] grav_ext, thrust_ext;
  logic signed [16:0] ts_ext;
  logic signed [25:0] dv;
  logic signed [26:0] vsum, spd;
  logic signed [23:0] vclamp, vneg;
  logic [22:0]        absv;
  logic [23:0]        div_in;
  logic signed [24:0] dh;
  logic signed [25:0] hsum;
  logic signed [23:0] hsat;
  logic signed [24:0] tgt_gap;
  logic [23:0]        gap_abs;
  logic [24:0]        x;
  logic               crash_d;
  logic [IdxW-1:0]    ia, ib;
  logic signed [17:0] diff;
  logic signed [24:0] exp_val, rsum;
  logic signed [23:0] rsat;
  logic [20:0]        q10;
  logic [15:0]        cnt_inc;

  assign grav_ext   = 25'(cfg_i.gravity_accel);
  assign thrust_ext = $signed({2'b00, cfg_i.thrust_accel});
  assign ts_ext     = $signed({1'b0, cfg_i.time_step});

  always_comb begin
    case (action_i)
      ActDown: accel_d = grav_ext - thrust_ext;
      ActUp:   accel_d = grav_ext + thrust_ext;
      default: accel_d = grav_ext;
    endcase
  end

  // velocity update: round, integrate, clamp
  assign mul_rnd = mul_q + 42'sd32768;
  assign dv      = 26'(mul_rnd >>> 16);
  assign vsum    = 27'(vel_q) + 27'(dv);
  assign spd     = $signed({4'b0000, cfg_i.speed_limit});

  always_comb begin
    if (vsum > spd) begin
      vclamp = 24'(spd);
    end else if (vsum < -spd) begin
      vclamp = 24'(-spd);
    end else begin
      vclamp = 24'(vsum);
    end
  end

  assign vneg   = -vnew_q;
  assign absv   = vnew_q[23] ? vneg[22:0] : vnew_q[22:0];
  assign div_in = {1'b0, absv} + 24'd5;

  // height update: round, integrate, saturate
  assign dh   = 25'(mul_rnd >>> 16);
  assign hsum = 26'(height_q) + 26'(dh);

  always_comb begin
    if (hsum > 26'sd8388607) begin
      hsat = 24'sh7FFFFF;
    end else if (hsum < -26'sd8388608) begin
      hsat = 24'sh800000;
    end else begin
      hsat = 24'(hsum);
    end
  end

  assign tgt_gap  = 25'(hnew_q) - $signed({2'b00, cfg_i.target_height});
  assign gap_abs  = tgt_gap[24] ? 24'(-tgt_gap) : tgt_gap[23:0];
  assign x        = {gap_abs, 1'b0};
  assign crash_d  = (hnew_q <= 24'sd0) || (hnew_q > $signed({1'b0, cfg_i.height_limit}));

  assign ia   = p_q[PW-1:20];
  assign ib   = ia + IdxW'(1);
  assign diff = $signed({1'b0, b_q}) - $signed({1'b0, a_q});

  // reward assembly
  assign ip_rnd  = ip_q + 35'sd32768;
  assign q10     = div_q[Div10Shift +: 21];
  assign exp_val = far_q ? 25'sd0 : ($signed({8'd0, a_q}) + 25'(ip_rnd >>> 16));
  assign rsum    = exp_val - $signed({4'd0, q10}) + RewardBias;

  always_comb begin
    if (crash_q) begin
      rsat = 24'(RewardCrash);
    end else if (rsum > 25'sd8388607) begin
      rsat = 24'sh7FFFFF;
    end else if (rsum < -25'sd8388608) begin
      rsat = 24'sh800000;
    end else begin
      rsat = 24'(rsum);
    end
  end

  assign cnt_inc = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(operation_i);
      start_q <= start_height_i;
      accel_q <= accel_d;
    end
    if (cmd_i.mul_dv) begin
      mul_q <= 42'(accel_q * ts_ext);
    end
    if (cmd_i.vel) begin
      vnew_q <= vclamp;
    end
    if (cmd_i.mul_dh) begin
      mul_q <= 42'(vnew_q * ts_ext);
      div_q <= div_in * Div10Mult;
    end
    if (cmd_i.hgt) begin
      hnew_q <= hsat;
    end
    if (cmd_i.mul_p) begin
      far_q   <= |x[24:20];
      crash_q <= crash_d;
      p_q     <= PW'(x[19:0]) * PW'(EXP_TABLE_ENTRIES);
    end
    if (cmd_i.rom) begin
      a_q <= exp_rom[ia];
      b_q <= exp_rom[ib];
      f_q <= p_q[19:4];
    end
    if (cmd_i.mul_i) begin
      ip_q <= 35'(diff * $signed({1'b0, f_q}));
    end
    if (cmd_i.commit) begin
      reward_q <= (op_q == OP_RESET) ? 24'sd0 : rsat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
      vel_q    <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      term_q   <= 1'b1;
    end else if (cmd_i.commit) begin
      if (op_q == OP_RESET) begin
        height_q <= $signed({1'b0, start_q});
        vel_q    <= '0;
        cnt_q    <= '0;
        done_q   <= 1'b0;
        term_q   <= 1'b1;
      end else begin
        height_q <= hnew_q;
        vel_q    <= vnew_q;
        cnt_q    <= cnt_inc;
        if (crash_q) begin
          done_q <= 1'b1;
          term_q <= 1'b1;
        end else if (cnt_inc >= cfg_i.step_limit) begin
          done_q <= 1'b1;
          term_q <= 1'b0;
        end
      end
    end
  end

  assign height_o         = height_q;
  assign velocity_o       = vel_q;
  assign reward_o         = reward_q;
  assign episode_done_o   = done_q;
  assign crash_terminal_o = term_q;

endmodule

/* src/hover_ball_env_step_unit.sv */
// Step item: taken only in idle, then walked through MUL_DV, VEL, MUL_DH,
// HGT, MUL_P, ROM, MUL_I and COMMIT, which waits while the output stalls.
// Reset item: straight from idle to COMMIT. The result beat is registered
// at COMMIT; no item is taken before it. The sequence follows one shared
// product register, the registered exponent table read and interpolation.
// Reset clears the ball state, sets terminal and loads register defaults.
module hover_ball_env_step_unit #(
  parameter int unsigned EXP_TABLE_ENTRIES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hbe_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hbe_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [1:0]                    action_i,
  input  logic [22:0]                   start_height_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [23:0]            height_o,
  output logic signed [23:0]            velocity_o,
  output logic signed [23:0]            reward_o,
  output logic                          episode_done_o,
  output logic                          crash_terminal_o
);
  import hbe_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  hbe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  hbe_datapath #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .operation_i      (operation_i),
    .action_i         (action_i),
    .start_height_i   (start_height_i),
    .height_o         (height_o),
    .velocity_o       (velocity_o),
    .reward_o         (reward_o),
    .episode_done_o   (episode_done_o),
    .crash_terminal_o (crash_terminal_o)
  );

endmodule
